// File: rtl/brbs_pkg.sv
// shared types and widths for the byte range block splitter
// no dependencies; imported by byte_range_block_splitter
`default_nettype none

package brbs_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 16;
    localparam int SIZE_W = 13;
    localparam int OFS_W  = 12;
    localparam int CNT_W  = 13;

    typedef enum logic [0:0] {
        CFG_BLOCK_SIZE      = 1'b0,
        CFG_BLOCK_INCREMENT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [LEN_W-1:0]  length;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [OFS_W-1:0]  start_offset;
        logic [CNT_W-1:0]  byte_count;
        logic [LEN_W-1:0]  dest_offset;
        logic              last_piece;
        logic              too_many_pieces;
    } piece_t;

endpackage

`default_nettype wire

// File: rtl/byte_range_block_splitter.sv
// byte range block splitter: microcoded sequencer with restoring divider
// depends on brbs_pkg
`default_nettype none

// Splits a (byte_address, length) request into one transaction per block touched:
// an unaligned head clipped to the length, whole blocks, then a tail from offset 0.
// A request first runs through a one-bit-per-cycle divider to find the block
// index and offset, then a multiply by block_increment and the piece limit
// check; after that one piece leaves per cycle while out_ready is high. The
// 32-step divider makes up the bulk of a request's time. Zero length yields one
// empty piece and too many pieces one error piece. One request is handled
// at a time; in_ready is high only while the sequencer waits for the next one.
// Configuration writes are taken at any time and must only come while idle.
module byte_range_block_splitter #(
    parameter int MAX_PIECES      = 64,
    parameter int MAX_BLOCK_BYTES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  brbs_pkg::req_t               in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output brbs_pkg::piece_t             out_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  brbs_pkg::cfg_index_t         cfg_index,
    input  logic [brbs_pkg::SIZE_W-1:0]  cfg_data
);
    import brbs_pkg::*;

    localparam int PIECE_W   = $clog2(MAX_PIECES + 1);
    localparam int LIMIT_W   = PIECE_W + SIZE_W;
    localparam int SPAN_W    = LEN_W + 1;
    localparam int CMP_W     = (LIMIT_W > SPAN_W) ? LIMIT_W : SPAN_W;
    localparam int DIV_STEPS = ADDR_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int PROD_W    = ADDR_W + SIZE_W;
    localparam logic [16:0]        MAX_BLK     = 17'(MAX_BLOCK_BYTES);
    localparam logic [PIECE_W-1:0] PIECE_LIMIT = PIECE_W'(MAX_PIECES);

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_DIV, OP_MUL, OP_PIECE, OP_ZERO, OP_ERR
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER, C_ALWAYS, C_DIV_MORE, C_ZERO_LEN, C_TOO_MANY, C_NOT_LAST
    } cond_t;

    typedef logic [3:0] upc_t;

    typedef struct packed {
        logic  accept;
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    localparam upc_t PC_LOAD  = 4'd0;
    localparam upc_t PC_DIV   = 4'd1;
    localparam upc_t PC_MUL   = 4'd2;
    localparam upc_t PC_ZCHK  = 4'd3;
    localparam upc_t PC_ECHK  = 4'd4;
    localparam upc_t PC_PIECE = 4'd5;
    localparam upc_t PC_DONE  = 4'd6;
    localparam upc_t PC_ZERO  = 4'd7;
    localparam upc_t PC_ERR   = 4'd8;

    // control store: a taken condition jumps to target, else falls through
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w = '{accept: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: PC_LOAD};
        case (pc)
            PC_LOAD:  w = '{accept: 1'b1, op: OP_LOAD,  cond: C_NEVER,    target: PC_LOAD};
            PC_DIV:   w = '{accept: 1'b0, op: OP_DIV,   cond: C_DIV_MORE, target: PC_DIV};
            PC_MUL:   w = '{accept: 1'b0, op: OP_MUL,   cond: C_NEVER,    target: PC_LOAD};
            PC_ZCHK:  w = '{accept: 1'b0, op: OP_NONE,  cond: C_ZERO_LEN, target: PC_ZERO};
            PC_ECHK:  w = '{accept: 1'b0, op: OP_NONE,  cond: C_TOO_MANY, target: PC_ERR};
            PC_PIECE: w = '{accept: 1'b0, op: OP_PIECE, cond: C_NOT_LAST, target: PC_PIECE};
            PC_DONE:  w = '{accept: 1'b0, op: OP_NONE,  cond: C_ALWAYS,   target: PC_LOAD};
            PC_ZERO:  w = '{accept: 1'b0, op: OP_ZERO,  cond: C_ALWAYS,   target: PC_LOAD};
            PC_ERR:   w = '{accept: 1'b0, op: OP_ERR,   cond: C_ALWAYS,   target: PC_LOAD};
            default:  w = '{accept: 1'b0, op: OP_NONE,  cond: C_ALWAYS,   target: PC_LOAD};
        endcase
        return w;
    endfunction

    // control state
    upc_t               pc_reg, pc_next;
    logic               out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0]  bsize_reg, bsize_next;
    logic [SIZE_W-1:0]  binc_reg, binc_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;

    // datapath
    logic [ADDR_W-1:0]  quo_reg, quo_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  block_reg, block_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]   dest_reg, dest_next;
    logic               head_reg, head_next;
    logic               too_many_reg, too_many_next;
    piece_t             out_item_reg, out_item_next;

    uword_t             cw;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    diff;
    logic               ge;
    logic [PROD_W-1:0]  prod;
    logic [LIMIT_W-1:0] limit;
    logic [SPAN_W-1:0]  span;
    logic [SIZE_W-1:0]  start;
    logic [SIZE_W-1:0]  room;
    logic [CNT_W-1:0]   cnt;
    logic               is_last;
    logic               emit;
    logic               fire;
    logic               cond_hit;

    assign cw        = ucode(pc_reg);
    assign in_ready  = cw.accept;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // block size clamped to 1..MAX_BLOCK_BYTES
    always_comb
    begin
        if (bsize_reg == '0)
            size = SIZE_W'(1);
        else if (17'(bsize_reg) > MAX_BLK)
            size = SIZE_W'(MAX_BLOCK_BYTES);
        else
            size = bsize_reg;
    end

    // one restoring division step
    assign trial = {rem_reg, quo_reg[ADDR_W-1]};
    assign ge    = trial >= {1'b0, size};
    assign diff  = trial - {1'b0, size};

    assign prod  = PROD_W'(quo_reg) * PROD_W'(binc_reg);
    assign limit = LIMIT_W'(PIECE_LIMIT) * LIMIT_W'(size);
    assign span  = SPAN_W'(rem_reg) + SPAN_W'(len_reg);

    // current piece
    assign start   = head_reg ? rem_reg : '0;
    assign room    = size - start;
    assign cnt     = (left_reg < LEN_W'(room)) ? CNT_W'(left_reg) : room;
    assign is_last = LEN_W'(cnt) == left_reg;

    assign emit = (cw.op == OP_PIECE) || (cw.op == OP_ZERO) || (cw.op == OP_ERR);
    assign fire = !((cw.accept && !in_valid) || (emit && out_valid_reg && !out_ready));

    always_comb
    begin
        case (cw.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_ALWAYS:   cond_hit = 1'b1;
            C_DIV_MORE: cond_hit = dcnt_reg != DCNT_W'(DIV_STEPS - 1);
            C_ZERO_LEN: cond_hit = len_reg == '0;
            C_TOO_MANY: cond_hit = too_many_reg;
            C_NOT_LAST: cond_hit = !is_last;
            default:    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        bsize_next     = bsize_reg;
        binc_next      = binc_reg;
        dcnt_next      = dcnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        block_next     = block_reg;
        left_next      = left_reg;
        dest_next      = dest_reg;
        head_next      = head_reg;
        too_many_next  = too_many_reg;
        out_item_next  = out_item_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:      bsize_next = cfg_data;
                CFG_BLOCK_INCREMENT: binc_next  = cfg_data;
                default:             ;
            endcase
        end

        if (out_ready)
            out_valid_next = 1'b0;

        if (fire)
        begin
            pc_next = cond_hit ? cw.target : pc_reg + upc_t'(1);
            case (cw.op)
                OP_LOAD:
                begin
                    quo_next  = in_item.byte_address;
                    rem_next  = '0;
                    dcnt_next = '0;
                    len_next  = in_item.length;
                    left_next = in_item.length;
                    dest_next = '0;
                end
                OP_DIV:
                begin
                    rem_next  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                    quo_next  = {quo_reg[ADDR_W-2:0], ge};
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
                OP_MUL:
                begin
                    block_next    = prod[ADDR_W-1:0];
                    head_next     = rem_reg != '0;
                    too_many_next = CMP_W'(span) > CMP_W'(limit);
                end
                OP_PIECE:
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{block_address: block_reg,
                                       start_offset: start[OFS_W-1:0],
                                       byte_count: cnt,
                                       dest_offset: dest_reg,
                                       last_piece: is_last,
                                       too_many_pieces: 1'b0};
                    left_next  = left_reg - LEN_W'(cnt);
                    block_next = block_reg + ADDR_W'(binc_reg);
                    dest_next  = dest_reg + LEN_W'(cnt);
                    head_next  = 1'b0;
                end
                OP_ZERO:
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{block_address: block_reg,
                                       start_offset: rem_reg[OFS_W-1:0],
                                       byte_count: '0,
                                       dest_offset: '0,
                                       last_piece: 1'b1,
                                       too_many_pieces: 1'b0};
                end
                OP_ERR:
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{block_address: '0,
                                       start_offset: '0,
                                       byte_count: '0,
                                       dest_offset: '0,
                                       last_piece: 1'b1,
                                       too_many_pieces: 1'b1};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_LOAD;
            out_valid_reg <= 1'b0;
            bsize_reg     <= SIZE_W'(512);
            binc_reg      <= SIZE_W'(1);
            dcnt_reg      <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            bsize_reg     <= bsize_next;
            binc_reg      <= binc_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        len_reg      <= len_next;
        block_reg    <= block_next;
        left_reg     <= left_next;
        dest_reg     <= dest_next;
        head_reg     <= head_next;
        too_many_reg <= too_many_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// File: dv/tb_byte_range_block_splitter.sv
`timescale 1ns / 1ps
// testbench for byte_range_block_splitter: directed and random byte ranges under several
// block geometries, every piece checked field by field; depends on brbs_pkg and the rtl top

module tb_byte_range_block_splitter;
    import brbs_pkg::*;

    localparam int PIECE_LIMIT     = 64;
    localparam int BLOCK_BYTES_MAX = 4096;
    localparam int DRAIN_CYCLES    = 48;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    req_t                in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    piece_t              out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_index_t          cfg_index = CFG_BLOCK_SIZE;
    logic [SIZE_W-1:0]   cfg_data  = '0;

    // shadow of the geometry registers, updated when a write transaction is taken
    logic [SIZE_W-1:0]   geo_block_size = 13'd512;
    logic [SIZE_W-1:0]   geo_block_incr = 13'd1;

    piece_t              expected_pieces[$];
    piece_t              want_piece;
    int                  fail_count = 0;
    int                  ready_hold = 0;
    int                  stall_draw;
    bit                  no_idle    = 1'b0;

    byte_range_block_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned effective_block_size();
        int unsigned size;
        size = geo_block_size;
        if (size == 0)
        begin
            size = 1;
        end
        if (size > BLOCK_BYTES_MAX)
        begin
            size = BLOCK_BYTES_MAX;
        end
        return size;
    endfunction

    // works out the pieces one request must produce and queues them
    function automatic void split_range(input req_t r);
        int unsigned       size;
        int unsigned       offset;
        int unsigned       pieces;
        int unsigned       start;
        int unsigned       room;
        int unsigned       cnt;
        int unsigned       left;
        logic [ADDR_W-1:0] blk;
        logic [LEN_W-1:0]  dest;
        bit                head;
        piece_t            p;
        size   = effective_block_size();
        offset = r.byte_address % size;
        blk    = ADDR_W'((r.byte_address / size) * geo_block_incr);
        p      = '0;
        if (r.length == 0)
        begin
            p.block_address = blk;
            p.start_offset  = OFS_W'(offset);
            p.last_piece    = 1'b1;
            expected_pieces.push_back(p);
            return;
        end
        pieces = (offset + r.length + size - 1) / size;
        if (pieces > PIECE_LIMIT)
        begin
            p.last_piece      = 1'b1;
            p.too_many_pieces = 1'b1;
            expected_pieces.push_back(p);
            return;
        end
        left = r.length;
        dest = '0;
        head = (offset != 0);
        for (int k = 0; k < pieces && left != 0; k++)
        begin
            start = head ? offset : 0;
            room  = size - start;
            cnt   = (left < room) ? left : room;
            p = '0;
            p.block_address = blk;
            p.start_offset  = OFS_W'(start);
            p.byte_count    = CNT_W'(cnt);
            p.dest_offset   = dest;
            p.last_piece    = (cnt == left);
            expected_pieces.push_back(p);
            left = left - cnt;
            if (p.last_piece)
            begin
                break;
            end
            blk  = blk + geo_block_incr;
            dest = dest + LEN_W'(cnt);
            head = 1'b0;
        end
    endfunction

    // receiver: random back-pressure per piece, compare against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_pieces.size() == 0)
            begin
                $error("unexpected piece transaction: %p", out_item);
                fail_count++;
            end
            else
            begin
                want_piece = expected_pieces.pop_front();
                if (out_item.block_address !== want_piece.block_address)
                begin
                    $error("block_address: expected %0h, actual %0h",
                           want_piece.block_address, out_item.block_address);
                    fail_count++;
                end
                if (out_item.start_offset !== want_piece.start_offset)
                begin
                    $error("start_offset: expected %0d, actual %0d",
                           want_piece.start_offset, out_item.start_offset);
                    fail_count++;
                end
                if (out_item.byte_count !== want_piece.byte_count)
                begin
                    $error("byte_count: expected %0d, actual %0d",
                           want_piece.byte_count, out_item.byte_count);
                    fail_count++;
                end
                if (out_item.dest_offset !== want_piece.dest_offset)
                begin
                    $error("dest_offset: expected %0d, actual %0d",
                           want_piece.dest_offset, out_item.dest_offset);
                    fail_count++;
                end
                if (out_item.last_piece !== want_piece.last_piece)
                begin
                    $error("last_piece: expected %0b, actual %0b",
                           want_piece.last_piece, out_item.last_piece);
                    fail_count++;
                end
                if (out_item.too_many_pieces !== want_piece.too_many_pieces)
                begin
                    $error("too_many_pieces: expected %0b, actual %0b",
                           want_piece.too_many_pieces, out_item.too_many_pieces);
                    fail_count++;
                end
            end
            stall_draw = no_idle ? 0 : $urandom_range(0, 11);
            ready_hold <= stall_draw;
            out_ready  <= (stall_draw == 0);
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= (ready_hold == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // valid is left high on return so a zero gap keeps it up for the next request
    task automatic send_req(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req_t'{byte_address: addr, length: len};
        do @(posedge clk); while (!in_ready);
        split_range(in_item);
    endtask

    task automatic wait_for_pieces();
        in_valid <= 1'b0;
        while (expected_pieces.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called once the block is idle
    task automatic set_geometry(input logic [SIZE_W-1:0] size, input logic [SIZE_W-1:0] incr);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data  <= size;
        do @(posedge clk); while (!cfg_ready);
        geo_block_size = size;
        cfg_index <= CFG_BLOCK_INCREMENT;
        cfg_data  <= incr;
        do @(posedge clk); while (!cfg_ready);
        geo_block_incr = incr;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_geometry();
        send_req(32'h0000_0000, 16'd0);
        send_req(32'h1234_5677, 16'd0);
        send_req(32'h0000_0000, 16'd512);
        send_req(32'h0000_0064, 16'd10);        // head clipped inside one block
        send_req(32'h0000_01fe, 16'd4);         // short unaligned span over a boundary
        send_req(32'h0000_012c, 16'd2000);      // head, whole blocks, tail
        send_req(32'h0000_0000, 16'hffff);      // far over the piece limit
        send_req(32'hffff_ffff, 16'd1);
        send_req(32'hffff_fe05, 16'd32763);     // exactly at the piece limit
        send_req(32'h0000_0005, 16'd32764);     // one piece over the limit
        send_req(32'h0000_0000, 16'd1);
        wait_for_pieces();
    endtask

    task automatic test_geometry_extremes();
        set_geometry(13'd1, 13'h1fff);
        send_req(32'h0000_0007, 16'd64);
        send_req(32'h0000_0007, 16'd65);
        wait_for_pieces();
        set_geometry(13'd0, 13'd0);             // zero size acts as one, zero step
        send_req(32'hffff_fff0, 16'd3);
        send_req(32'h8000_0001, 16'd0);
        wait_for_pieces();
        set_geometry(13'h1fff, 13'h1fff);       // oversize saturates, addresses wrap
        send_req(32'hffff_ffff, 16'hffff);
        send_req(32'hffff_f000, 16'd4096);
        wait_for_pieces();
        set_geometry(13'd4096, 13'd0);
        send_req(32'h0000_3001, 16'd9000);
        wait_for_pieces();
        set_geometry(13'd4096, 13'd4096);
        send_req(32'h8000_0000, 16'd4096);
        send_req(32'h7fff_ffff, 16'd2);
        wait_for_pieces();
    endtask

    task automatic run_random_ranges(input int count);
        logic [ADDR_W-1:0] addr;
        int unsigned       size;
        int unsigned       offset;
        int unsigned       len;
        int unsigned       mode;
        for (int n = 0; n < count; n++)
        begin
            size = effective_block_size();
            mode = $urandom_range(0, 15);
            addr = $urandom();
            if (mode < 3)
            begin
                addr = addr - (addr % size);
            end
            else if (mode == 3)
            begin
                addr = 32'hffff_ffff - $urandom_range(0, 8191);
            end
            offset = addr % size;
            if (mode == 4)
            begin
                len = 0;
            end
            else if (mode == 5)
            begin
                len = $urandom() & 32'hffff;
            end
            else if (mode == 6 || mode == 7)
            begin
                // land on either side of the piece limit
                len = PIECE_LIMIT * size - offset + $urandom_range(0, 2) - 1;
                if (len < 1)
                begin
                    len = 1;
                end
            end
            else
            begin
                len = $urandom_range(1, size * $urandom_range(1, 6));
            end
            if (len > 16'hffff)
            begin
                len = 16'hffff;
            end
            if ($urandom_range(0, 24) == 0)
            begin
                wait_for_pieces();
            end
            send_req(addr, LEN_W'(len));
        end
        wait_for_pieces();
    endtask

    task automatic test_random_ranges();
        set_geometry(13'd512, 13'd1);
        no_idle = 1'b1;
        run_random_ranges(12);
        no_idle = 1'b0;
        run_random_ranges(12);
        set_geometry(13'd1, 13'h1fff);
        run_random_ranges(22);
        set_geometry(13'd4096, 13'd4096);
        run_random_ranges(22);
        set_geometry(13'd0, 13'd0);
        run_random_ranges(22);
        set_geometry(13'h1fff, 13'd1);
        run_random_ranges(22);
        set_geometry(13'd3, 13'd7);
        run_random_ranges(24);
        set_geometry(13'd100, 13'd3000);
        run_random_ranges(24);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_geometry_extremes();
        test_random_ranges();
        wait_for_pieces();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d pieces still expected", expected_pieces.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/brbs_pkg.sv
rtl/byte_range_block_splitter.sv
dv/tb_byte_range_block_splitter.sv
